FILE: src/sgpd_pkg.sv
package sgpd_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int NUM_SCALES  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_SIZE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FEATURE_COUNT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_0       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_1       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_2       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_3       = 3'd5;

    localparam logic [6:0]  GRID_SIZE_RESET     = 7'd64;
    localparam logic [2:0]  FEATURE_COUNT_RESET = 3'd2;
    localparam logic [15:0] SCALE_RESET         = 16'd256;

    localparam logic [2:0]  MAX_FEATURES = 3'd4;

    localparam logic [16:0] SLOT_LIMIT = 17'd65536;
    localparam logic [15:0] SLOT_MAX   = 16'hFFFF;

endpackage

FILE: src/sparse_grid_point_dedup.sv
// First-point voxelization of 2-D point pictures.
// Input channel (in_valid / in_stall) carries one point or one empty-picture
// marker per transaction; output channel (out_valid / out_stall) carries at
// most one result per input transaction, in input order.
// A point is accepted in idle, then looked up: the accept cycle clamps the
// coordinates, forms the cell number and reads the cell's generation tag
// from the tag RAM; the next cycle compares the tag and, for a new cell,
// writes it back and registers the scaled features. No item is accepted
// until the single tag RAM's read-compare-write ends. Markers skip the lookup.
// Results sit in an output register; a new item is accepted while that
// register drains in the same cycle, so out_stall holds off input only while
// a result waits.
// After reset the tag RAM is swept to zero, one entry per cycle, over all
// GRID_SIDE*GRID_SIDE entries (4096 by default) with in_stall high; when the
// generation tag wraps the same sweep runs again after that point's result.
// Configuration writes are taken in any cycle and must be done while idle.
module sparse_grid_point_dedup
    import sgpd_pkg::*;
#(
    parameter int GRID_SIDE  = 64,
    parameter int MAX_ACTIVE = 65536,
    parameter int GEN_BITS   = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   req_type,
    input  logic                   first_of_picture,
    input  logic                   new_batch,
    input  logic signed [15:0]     coord_x,
    input  logic signed [15:0]     coord_y,
    input  logic signed [15:0]     feature_0,
    input  logic signed [15:0]     feature_1,
    input  logic signed [15:0]     feature_2,
    input  logic signed [15:0]     feature_3,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   is_empty_picture,
    output logic [15:0]            picture_slot,
    output logic [11:0]            cell_number,
    output logic [15:0]            point_index,
    output logic signed [15:0]     scaled_0,
    output logic signed [15:0]     scaled_1,
    output logic signed [15:0]     scaled_2,
    output logic signed [15:0]     scaled_3,
    output logic                   index_overflow
);

    localparam int CELLS   = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W  = $clog2(CELLS);
    localparam int COORD_W = $clog2(GRID_SIDE);
    localparam int SIDE_W  = $clog2(GRID_SIDE + 1);
    localparam int PROD_W  = COORD_W + SIDE_W;
    localparam int NI_W    = $clog2(MAX_ACTIVE + 1);
    localparam int IDX_W   = $clog2(MAX_ACTIVE);

    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic signed [15:0] c,
        input logic [COORD_W-1:0] lim
    );
        if (c[15])
        begin
            return '0;
        end
        else if ({16'b0, c} > 32'(lim))
        begin
            return lim;
        end
        return c[COORD_W-1:0];
    endfunction

    function automatic logic signed [15:0] scale_q88(
        input logic signed [15:0] f,
        input logic [15:0]        s
    );
        logic signed [32:0] p;
        logic signed [24:0] q;
        p = $signed({{17{f[15]}}, f}) * $signed({17'b0, s});
        p = p + 33'sd128;
        q = p[32:8];
        if (q > 25'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (q < -25'sd32768)
        begin
            return 16'sh8000;
        end
        return q[15:0];
    endfunction

    state_t                      state_reg, state_next;
    logic [CELL_W-1:0]           clr_cnt_reg, clr_cnt_next;
    logic                        keep_reg, keep_next;
    logic                        wrap_reg, wrap_next;
    logic [GEN_BITS-1:0]         cur_gen_reg, cur_gen_next;
    logic [NI_W-1:0]             next_index_reg, next_index_next;
    logic [16:0]                 next_slot_reg, next_slot_next;
    logic [15:0]                 current_slot_reg, current_slot_next;
    logic                        out_valid_reg, out_valid_next;

    logic [6:0]                  grid_size_reg;
    logic [2:0]                  feature_count_reg;
    logic [15:0]                 scale_reg [NUM_SCALES];

    logic [CELL_W-1:0]           cell_reg, cell_next;
    logic signed [15:0]          feat_reg [NUM_SCALES];

    logic                        is_empty_reg, is_empty_next;
    logic [15:0]                 slot_out_reg, slot_out_next;
    logic [11:0]                 cell_out_reg, cell_out_next;
    logic [15:0]                 index_out_reg, index_out_next;
    logic signed [15:0]          scaled_reg [NUM_SCALES];
    logic signed [15:0]          scaled_next [NUM_SCALES];
    logic                        ovf_reg, ovf_next;
    logic                        out_load;

    logic                        in_accept;
    logic                        out_free;
    logic [SIDE_W-1:0]           side;
    logic [SIDE_W-1:0]           side_dec;
    logic [COORD_W-1:0]          side_m1;
    logic [COORD_W-1:0]          x_c, y_c;
    logic [PROD_W-1:0]           cell_prod;
    logic [CELL_W-1:0]           cell_in;
    logic [2:0]                  nf;

    logic                        ram_wr_en;
    logic [CELL_W-1:0]           ram_wr_addr;
    logic [GEN_BITS-1:0]         ram_wr_data;
    logic                        ram_rd_en;
    logic [GEN_BITS-1:0]         ram_rd_data;

    sgpd_ram #(
        .WIDTH (GEN_BITS),
        .DEPTH (CELLS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (cell_in),
        .rd_data (ram_rd_data)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (grid_size_reg == 7'd0)
        begin
            side = SIDE_W'(1);
        end
        else if (32'(grid_size_reg) > GRID_SIDE)
        begin
            side = SIDE_W'(GRID_SIDE);
        end
        else
        begin
            side = SIDE_W'(grid_size_reg);
        end
        side_dec  = side - SIDE_W'(1);
        side_m1   = side_dec[COORD_W-1:0];
        x_c       = clamp_coord(coord_x, side_m1);
        y_c       = clamp_coord(coord_y, side_m1);
        cell_prod = PROD_W'(x_c) * PROD_W'(side) + PROD_W'(y_c);
        cell_in   = cell_prod[CELL_W-1:0];

        if (feature_count_reg == 3'd0)
        begin
            nf = 3'd1;
        end
        else if (feature_count_reg > MAX_FEATURES)
        begin
            nf = MAX_FEATURES;
        end
        else
        begin
            nf = feature_count_reg;
        end
    end

    always_comb
    begin
        logic [16:0]         ns_base;
        logic [NI_W-1:0]     ni_base;
        logic [GEN_BITS-1:0] gen_inc;
        logic                hit;
        logic                sat;
        logic [IDX_W-1:0]    idx;
        logic [31:0]         idx_wide;
        logic [31:0]         cell_wide;

        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        keep_next         = keep_reg;
        wrap_next         = wrap_reg;
        cur_gen_next      = cur_gen_reg;
        next_index_next   = next_index_reg;
        next_slot_next    = next_slot_reg;
        current_slot_next = current_slot_reg;
        cell_next         = cell_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_load          = 1'b0;

        is_empty_next  = is_empty_reg;
        slot_out_next  = slot_out_reg;
        cell_out_next  = cell_out_reg;
        index_out_next = index_out_reg;
        ovf_next       = ovf_reg;
        for (int k = 0; k < NUM_SCALES; k++)
        begin
            scaled_next[k] = scaled_reg[k];
        end

        ram_wr_en   = 1'b0;
        ram_wr_addr = cell_reg;
        ram_wr_data = cur_gen_reg;
        ram_rd_en   = 1'b0;

        ns_base   = new_batch ? 17'd0 : next_slot_reg;
        ni_base   = new_batch ? '0 : next_index_reg;
        gen_inc   = cur_gen_reg + GEN_BITS'(1);
        hit       = !wrap_reg && (ram_rd_data == cur_gen_reg);
        sat       = next_index_reg >= NI_W'(MAX_ACTIVE);
        idx       = sat ? IDX_W'(MAX_ACTIVE - 1) : next_index_reg[IDX_W-1:0];
        idx_wide  = 32'(idx);
        cell_wide = 32'(cell_reg);

        case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_cnt_reg;
                ram_wr_data = (keep_reg && (clr_cnt_reg == cell_reg)) ? cur_gen_reg : '0;
                if (clr_cnt_reg == CELL_W'(CELLS - 1))
                begin
                    clr_cnt_next = '0;
                    keep_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + CELL_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_accept)
                begin
                    next_index_next = ni_base;
                    next_slot_next  = ns_base;
                    if (req_type)
                    begin
                        out_load       = 1'b1;
                        out_valid_next = 1'b1;
                        is_empty_next  = 1'b1;
                        slot_out_next  = '0;
                        cell_out_next  = '0;
                        index_out_next = '0;
                        ovf_next       = ni_base >= NI_W'(MAX_ACTIVE);
                        for (int k = 0; k < NUM_SCALES; k++)
                        begin
                            scaled_next[k] = '0;
                        end
                    end
                    else
                    begin
                        ram_rd_en  = 1'b1;
                        cell_next  = cell_in;
                        wrap_next  = 1'b0;
                        state_next = ST_LOOKUP;
                        if (first_of_picture || (cur_gen_reg == '0))
                        begin
                            if (gen_inc == '0)
                            begin
                                wrap_next    = 1'b1;
                                cur_gen_next = GEN_BITS'(1);
                            end
                            else
                            begin
                                cur_gen_next = gen_inc;
                            end
                            if (ns_base < SLOT_LIMIT)
                            begin
                                current_slot_next = ns_base[15:0];
                                next_slot_next    = ns_base + 17'd1;
                            end
                            else
                            begin
                                current_slot_next = SLOT_MAX;
                            end
                        end
                    end
                end
            end

            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
                if (!hit)
                begin
                    ram_wr_en       = !wrap_reg;
                    next_index_next = sat ? NI_W'(MAX_ACTIVE) : next_index_reg + NI_W'(1);
                    out_load        = 1'b1;
                    out_valid_next  = 1'b1;
                    is_empty_next   = 1'b0;
                    slot_out_next   = current_slot_reg;
                    cell_out_next   = cell_wide[11:0];
                    index_out_next  = idx_wide[15:0];
                    ovf_next        = sat;
                    for (int k = 0; k < NUM_SCALES; k++)
                    begin
                        scaled_next[k] = (3'(k) < nf) ? scale_q88(feat_reg[k], scale_reg[k])
                                                      : 16'sd0;
                    end
                    if (wrap_reg)
                    begin
                        keep_next    = 1'b1;
                        clr_cnt_next = '0;
                        state_next   = ST_CLEAR;
                    end
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_cnt_reg       <= '0;
            keep_reg          <= 1'b0;
            wrap_reg          <= 1'b0;
            cur_gen_reg       <= '0;
            next_index_reg    <= '0;
            next_slot_reg     <= '0;
            current_slot_reg  <= '0;
            out_valid_reg     <= 1'b0;
            grid_size_reg     <= GRID_SIZE_RESET;
            feature_count_reg <= FEATURE_COUNT_RESET;
            for (int k = 0; k < NUM_SCALES; k++)
            begin
                scale_reg[k] <= SCALE_RESET;
            end
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            keep_reg         <= keep_next;
            wrap_reg         <= wrap_next;
            cur_gen_reg      <= cur_gen_next;
            next_index_reg   <= next_index_next;
            next_slot_reg    <= next_slot_next;
            current_slot_reg <= current_slot_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_GRID_SIZE:     grid_size_reg     <= cfg_data[6:0];
                    REG_FEATURE_COUNT: feature_count_reg <= cfg_data[2:0];
                    REG_SCALE_0:       scale_reg[0]      <= cfg_data;
                    REG_SCALE_1:       scale_reg[1]      <= cfg_data;
                    REG_SCALE_2:       scale_reg[2]      <= cfg_data;
                    REG_SCALE_3:       scale_reg[3]      <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
        if (in_accept)
        begin
            feat_reg[0] <= feature_0;
            feat_reg[1] <= feature_1;
            feat_reg[2] <= feature_2;
            feat_reg[3] <= feature_3;
        end
        if (out_load)
        begin
            is_empty_reg  <= is_empty_next;
            slot_out_reg  <= slot_out_next;
            cell_out_reg  <= cell_out_next;
            index_out_reg <= index_out_next;
            ovf_reg       <= ovf_next;
            for (int k = 0; k < NUM_SCALES; k++)
            begin
                scaled_reg[k] <= scaled_next[k];
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign is_empty_picture = is_empty_reg;
    assign picture_slot     = slot_out_reg;
    assign cell_number      = cell_out_reg;
    assign point_index      = index_out_reg;
    assign scaled_0         = scaled_reg[0];
    assign scaled_1         = scaled_reg[1];
    assign scaled_2         = scaled_reg[2];
    assign scaled_3         = scaled_reg[3];
    assign index_overflow   = ovf_reg;

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> (state_reg == ST_IDLE))
        else $error("transaction accepted outside idle");

    a_lookup_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) |-> !out_valid_reg)
        else $error("lookup with output register still occupied");

    a_point_enters_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !req_type) |=> (state_reg == ST_LOOKUP) && (cur_gen_reg != '0))
        else $error("point not looked up under a live generation");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_index_reg <= NI_W'(MAX_ACTIVE))
        else $error("active index counter beyond limit");

    a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP && wrap_reg) |=> (state_reg == ST_CLEAR) && keep_reg)
        else $error("generation wrap without tag sweep");

endmodule

FILE: src/sgpd_ram.sv
module sgpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: test/tb_sparse_grid_point_dedup.sv
`timescale 1ns / 1ps

module tb_sparse_grid_point_dedup;
    import sgpd_pkg::*;

    localparam int GRID_SIDE   = 64;
    localparam int GRID_CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int MAX_ACTIVE  = 65536;
    localparam int STUCK_LIMIT = 20000;
    localparam int HOLDOFF_LEN = 80;

    localparam logic REQ_POINT = 1'b0;
    localparam logic REQ_EMPTY = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic               req;
        logic               first;
        logic               batch;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [3:0][15:0]   feat;
    } point_item_t;

    typedef struct packed {
        logic             empty;
        logic [15:0]      slot;
        logic [11:0]      cell_no;
        logic [15:0]      index;
        logic [3:0][15:0] scaled;
        logic             overflow;
    } voxel_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   req_type = 1'b0;
    logic                   first_of_picture = 1'b0;
    logic                   new_batch = 1'b0;
    logic signed [15:0]     coord_x = '0;
    logic signed [15:0]     coord_y = '0;
    logic signed [15:0]     feature_0 = '0;
    logic signed [15:0]     feature_1 = '0;
    logic signed [15:0]     feature_2 = '0;
    logic signed [15:0]     feature_3 = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   is_empty_picture;
    logic [15:0]            picture_slot;
    logic [11:0]            cell_number;
    logic [15:0]            point_index;
    logic signed [15:0]     scaled_0;
    logic signed [15:0]     scaled_1;
    logic signed [15:0]     scaled_2;
    logic signed [15:0]     scaled_3;
    logic                   index_overflow;

    // predictor state
    logic [7:0]  cell_tag [GRID_CELLS];
    logic [7:0]  picture_gen;
    logic [16:0] index_count;
    logic [16:0] slot_count;
    logic [15:0] picture_slot_now;
    logic [6:0]  grid_reg;
    logic [2:0]  feat_count_reg;
    logic [15:0] scale_reg [NUM_SCALES];

    voxel_result_t pending_voxels [$];
    int            mismatches = 0;
    bit            tx_idle_on = 1'b1;
    bit            rx_idle_on = 1'b1;
    int            holdoff_requests = 0;
    int            holdoff_seen = 0;
    int            holdoff_left = 0;
    int            stuck_cycles = 0;

    sparse_grid_point_dedup u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .first_of_picture (first_of_picture),
        .new_batch        (new_batch),
        .coord_x          (coord_x),
        .coord_y          (coord_y),
        .feature_0        (feature_0),
        .feature_1        (feature_1),
        .feature_2        (feature_2),
        .feature_3        (feature_3),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .is_empty_picture (is_empty_picture),
        .picture_slot     (picture_slot),
        .cell_number      (cell_number),
        .point_index      (point_index),
        .scaled_0         (scaled_0),
        .scaled_1         (scaled_1),
        .scaled_2         (scaled_2),
        .scaled_3         (scaled_3),
        .index_overflow   (index_overflow)
    );

    always #6 clk = ~clk;

    function automatic void predictor_reset();
        foreach (cell_tag[i])
        begin
            cell_tag[i] = '0;
        end
        picture_gen      = '0;
        index_count      = '0;
        slot_count       = '0;
        picture_slot_now = '0;
        grid_reg         = GRID_SIZE_RESET;
        feat_count_reg   = FEATURE_COUNT_RESET;
        foreach (scale_reg[i])
        begin
            scale_reg[i] = SCALE_RESET;
        end
    endfunction

    function automatic int effective_side();
        int s;
        s = int'(grid_reg);
        if (s < 1)
        begin
            s = 1;
        end
        if (s > GRID_SIDE)
        begin
            s = GRID_SIDE;
        end
        return s;
    endfunction

    function automatic int clamp_axis(logic signed [15:0] c, int side);
        int v;
        v = c;
        if (v < 0)
        begin
            return 0;
        end
        if (v > side - 1)
        begin
            return side - 1;
        end
        return v;
    endfunction

    function automatic logic [15:0] scaled_feature(logic signed [15:0] f, logic [15:0] s);
        longint p;
        longint q;
        p = longint'(f) * longint'({1'b0, s}) + 128;
        q = p >>> 8;
        if (q > 32767)
        begin
            q = 32767;
        end
        if (q < -32768)
        begin
            q = -32768;
        end
        return 16'(q);
    endfunction

    // first-point voxelization of one transaction; returns 1 when a result follows
    function automatic bit voxelize_item(input point_item_t it, output voxel_result_t r);
        int         side;
        int         cx;
        int         cy;
        int         cell_id;
        int         nf;
        logic [7:0] gen_next;
        r = '0;
        if (it.batch)
        begin
            index_count = '0;
            slot_count  = '0;
        end
        if (it.req == REQ_EMPTY)
        begin
            r.empty    = 1'b1;
            r.overflow = (index_count >= MAX_ACTIVE);
            return 1'b1;
        end
        if (it.first || picture_gen == '0)
        begin
            gen_next = picture_gen + 8'd1;
            if (gen_next == '0)
            begin
                foreach (cell_tag[i])
                begin
                    cell_tag[i] = '0;
                end
                gen_next = 8'd1;
            end
            picture_gen      = gen_next;
            picture_slot_now = (slot_count < SLOT_LIMIT) ? slot_count[15:0] : SLOT_MAX;
            if (slot_count < SLOT_LIMIT)
            begin
                slot_count = slot_count + 17'd1;
            end
        end
        side    = effective_side();
        cx      = clamp_axis(it.x, side);
        cy      = clamp_axis(it.y, side);
        cell_id = cx * side + cy;
        if (cell_tag[cell_id] == picture_gen)
        begin
            return 1'b0;
        end
        cell_tag[cell_id] = picture_gen;
        if (index_count >= MAX_ACTIVE)
        begin
            index_count = 17'(MAX_ACTIVE);
            r.index     = 16'(MAX_ACTIVE - 1);
            r.overflow  = 1'b1;
        end
        else
        begin
            r.index     = index_count[15:0];
            index_count = index_count + 17'd1;
        end
        nf = int'(feat_count_reg);
        if (nf < 1)
        begin
            nf = 1;
        end
        if (nf > int'(MAX_FEATURES))
        begin
            nf = int'(MAX_FEATURES);
        end
        r.slot    = picture_slot_now;
        r.cell_no = 12'(cell_id);
        for (int k = 0; k < nf; k++)
        begin
            r.scaled[k] = scaled_feature(it.feat[k], scale_reg[k]);
        end
        return 1'b1;
    endfunction

    function automatic logic [15:0] random_feature();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h0080;
            5: return 16'hFF80;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] random_coord(int side);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            return 16'($urandom_range(0, side - 1));
        end
        if (pick < 85)
        begin
            return 16'(side + $urandom_range(0, 3));
        end
        if (pick < 90)
        begin
            return 16'(-$urandom_range(1, 4));
        end
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] random_scale();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            return 16'h0000;
        end
        if (pick < 24)
        begin
            return 16'hFFFF;
        end
        if (pick < 36)
        begin
            return SCALE_RESET;
        end
        if (pick < 70)
        begin
            return 16'($urandom_range(0, 1023));
        end
        return 16'($urandom);
    endfunction

    function automatic point_item_t make_point(bit first, bit batch, logic [15:0] x,
                                               logic [15:0] y);
        point_item_t it;
        it.req   = REQ_POINT;
        it.first = first;
        it.batch = batch;
        it.x     = x;
        it.y     = y;
        for (int k = 0; k < 4; k++)
        begin
            it.feat[k] = random_feature();
        end
        return it;
    endfunction

    function automatic point_item_t make_empty(bit batch);
        point_item_t it;
        it     = make_point($urandom_range(0, 1), batch, 16'($urandom), 16'($urandom));
        it.req = REQ_EMPTY;
        return it;
    endfunction

    task automatic send_item(point_item_t it);
        voxel_result_t r;
        @(negedge clk);
        while (tx_idle_on && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        req_type         <= it.req;
        first_of_picture <= it.first;
        new_batch        <= it.batch;
        coord_x          <= it.x;
        coord_y          <= it.y;
        feature_0        <= it.feat[0];
        feature_1        <= it.feat[1];
        feature_2        <= it.feat[2];
        feature_3        <= it.feat[3];
        in_valid         <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (voxelize_item(it, r))
        begin
            pending_voxels = {pending_voxels, r};
        end
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // drain results, let duplicates retire and any tag sweep finish
    task automatic settle();
        release_input();
        while (pending_voxels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_GRID_SIZE:     grid_reg = data[6:0];
            REG_FEATURE_COUNT: feat_count_reg = data[2:0];
            REG_SCALE_0:       scale_reg[0] = data;
            REG_SCALE_1:       scale_reg[1] = data;
            REG_SCALE_2:       scale_reg[2] = data;
            REG_SCALE_3:       scale_reg[3] = data;
            default:           ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic write_shape(int grid, int count);
        write_reg(REG_GRID_SIZE, {9'($urandom), 7'(grid)});
        write_reg(REG_FEATURE_COUNT, {13'($urandom), 3'(count)});
    endtask

    task automatic check_voxel();
        voxel_result_t w;
        logic [15:0]   want [9];
        logic [15:0]   got [9];
        string         field [9];
        field = '{"is_empty_picture", "picture_slot", "cell_number", "point_index",
                  "scaled_0", "scaled_1", "scaled_2", "scaled_3", "index_overflow"};
        if (pending_voxels.size() == 0)
        begin
            mismatches++;
            $error("result with no transaction pending: cell_number %0d", cell_number);
            return;
        end
        w    = pending_voxels.pop_front();
        want = '{16'(w.empty), w.slot, 16'(w.cell_no), w.index, w.scaled[0], w.scaled[1],
                 w.scaled[2], w.scaled[3], 16'(w.overflow)};
        got  = '{16'(is_empty_picture), picture_slot, 16'(cell_number), point_index,
                 scaled_0, scaled_1, scaled_2, scaled_3, 16'(index_overflow)};
        for (int i = 0; i < 9; i++)
        begin
            if (got[i] !== want[i])
            begin
                mismatches++;
                $error("%s: expected 0x%04h, got 0x%04h", field[i], want[i], got[i]);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            check_voxel();
        end
    end

    always @(negedge clk)
    begin
        if (holdoff_requests != holdoff_seen)
        begin
            holdoff_seen = holdoff_requests;
            holdoff_left = HOLDOFF_LEN;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left = holdoff_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= rx_idle_on && ($urandom_range(0, 99) < 29);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic test_reset_state();
        point_item_t it;
        // point with no picture started yet
        it         = make_point(1'b0, 1'b0, 16'd0, 16'd0);
        it.feat[0] = 16'h7FFF;
        it.feat[1] = 16'h8000;
        send_item(it);
        send_item(make_point(1'b0, 1'b0, 16'd0, 16'd0));
        send_item(make_point(1'b0, 1'b0, 16'h8000, 16'h7FFF));
        send_item(make_point(1'b0, 1'b0, 16'h7FFF, 16'h8000));
        send_item(make_point(1'b0, 1'b0, 16'h7FFF, 16'h7FFF));
        send_item(make_empty(1'b0));
        send_item(make_point(1'b1, 1'b0, 16'd0, 16'd0));
        it         = make_point(1'b1, 1'b1, 16'd5, 16'd7);
        it.feat[0] = 16'hFFFF;
        it.feat[1] = 16'h0000;
        send_item(it);
        send_item(make_empty(1'b1));
        settle();
    endtask

    task automatic test_register_corners();
        point_item_t it;
        write_shape(0, 0);
        write_reg(REG_SCALE_0, 16'hFFFF);
        write_reg(REG_SCALE_1, 16'h0000);
        write_reg(REG_SCALE_2, 16'h0001);
        write_reg(REG_SCALE_3, 16'h8000);
        write_reg(REG_SPARE_6, 16'($urandom));
        write_reg(REG_SPARE_7, 16'($urandom));
        send_item(make_point(1'b1, 1'b0, 16'd5, 16'hFFFD));
        send_item(make_point(1'b0, 1'b0, 16'd0, 16'd0));
        settle();
        write_shape(127, 7);
        it         = make_point(1'b1, 1'b0, 16'd100, 16'd100);
        it.feat[0] = 16'h8000;
        send_item(it);
        send_item(make_point(1'b0, 1'b0, 16'd63, 16'd62));
        settle();
        write_shape(65, 4);
        send_item(make_point(1'b1, 1'b0, 16'd64, 16'd3));
        send_item(make_point(1'b0, 1'b0, 16'd2, 16'd64));
        settle();
        write_shape(5, 5);
        send_item(make_point(1'b1, 1'b0, 16'd4, 16'd9));
        send_item(make_point(1'b0, 1'b0, 16'hFFFF, 16'd2));
        settle();
        write_shape(64, 3);
        write_reg(REG_SCALE_0, 16'h0000);
        write_reg(REG_SCALE_1, 16'hFFFF);
        write_reg(REG_SCALE_2, 16'h7FFF);
        write_reg(REG_SCALE_3, SCALE_RESET);
        send_item(make_point(1'b1, 1'b0, 16'd63, 16'd0));
        send_item(make_point(1'b0, 1'b0, 16'd1, 16'd1));
        settle();
    endtask

    task automatic test_output_holdoff();
        write_shape(64, 4);
        holdoff_requests++;
        for (int i = 0; i < 30; i++)
        begin
            send_item(make_point(i == 0, 1'b0, random_coord(64), random_coord(64)));
        end
        settle();
    endtask

    task automatic test_generation_wrap();
        point_item_t it;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_shape(4, 1);
        for (int p = 0; p < 260; p++)
        begin
            it = make_point(1'b1, 1'b0, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)));
            send_item(it);
            if (p % 8 == 0)
            begin
                it.first = 1'b0;
                send_item(it);
            end
        end
        settle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_pictures(int phases, int per_phase);
        point_item_t it;
        point_item_t last;
        int          sent;
        int          grid;
        int          count;
        int          len;
        for (int ph = 0; ph < phases; ph++)
        begin
            case (ph)
                0:       begin grid = 64; count = 4; end
                1:       begin grid = 1; count = 0; end
                2:       begin grid = 127; count = $urandom_range(0, 7); end
                3:       begin grid = $urandom_range(2, 16); count = $urandom_range(0, 7); end
                default: begin grid = $urandom_range(0, 127); count = $urandom_range(0, 7); end
            endcase
            write_shape(grid, count);
            write_reg(REG_SCALE_0, random_scale());
            write_reg(REG_SCALE_1, random_scale());
            write_reg(REG_SCALE_2, random_scale());
            write_reg(REG_SCALE_3, random_scale());
            sent = 0;
            last = make_point(1'b1, 1'b0, 16'd0, 16'd0);
            while (sent < per_phase)
            begin
                if ($urandom_range(0, 99) < 6)
                begin
                    send_item(make_empty($urandom_range(0, 99) < 10));
                    sent++;
                end
                else
                begin
                    len = $urandom_range(1, 8);
                    for (int j = 0; j < len; j++)
                    begin
                        it = make_point(j == 0, (j == 0) && ($urandom_range(0, 99) < 5),
                                        random_coord(effective_side()),
                                        random_coord(effective_side()));
                        if (j > 0 && $urandom_range(0, 99) < 30)
                        begin
                            it.x = last.x;
                            it.y = last.y;
                        end
                        // noise: stray picture starts, markers and batch resets
                        if ($urandom_range(0, 99) < 8)
                        begin
                            it.first = $urandom_range(0, 1);
                        end
                        if ($urandom_range(0, 99) < 3)
                        begin
                            it.req = REQ_EMPTY;
                        end
                        if ($urandom_range(0, 99) < 2)
                        begin
                            it.batch = 1'b1;
                        end
                        send_item(it);
                        last = it;
                        sent++;
                    end
                end
            end
            settle();
        end
    endtask

    initial
    begin
        int waited;
        predictor_reset();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_register_corners();
        test_output_holdoff();
        test_generation_wrap();
        test_random_pictures(5, 100);
        release_input();
        waited = 0;
        while (pending_voxels.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (pending_voxels.size() != 0)
        begin
            mismatches++;
            $error("%0d results never arrived", pending_voxels.size());
        end
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
